>>> hw/rtl/jsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsw_pkg
// Shared types, codes and character tables of the JSON structural writer.
// ----------------------------------------------------------------------------
package jsw_pkg;

  localparam int MASK_W     = 11;
  localparam int LVL_MAX_W  = 3;
  localparam int SP_W       = 5;
  localparam int INT_W      = 64;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int BIT_CNT_W  = 7;

  localparam logic [MASK_W-1:0] A_OBJ_BEGIN   = 11'h001;
  localparam logic [MASK_W-1:0] A_OBJ_END     = 11'h002;
  localparam logic [MASK_W-1:0] A_ARR_BEGIN   = 11'h004;
  localparam logic [MASK_W-1:0] A_ARR_END     = 11'h008;
  localparam logic [MASK_W-1:0] A_KEY         = 11'h010;
  localparam logic [MASK_W-1:0] A_STRING      = 11'h020;
  localparam logic [MASK_W-1:0] A_NUMBER      = 11'h040;
  localparam logic [MASK_W-1:0] A_BOOL        = 11'h080;
  localparam logic [MASK_W-1:0] A_NULL        = 11'h100;
  localparam logic [MASK_W-1:0] A_VALUES_ONLY = 11'h200;
  localparam logic [MASK_W-1:0] A_NEXT        = 11'h400;
  localparam logic [MASK_W-1:0] A_VALUE =
    A_OBJ_BEGIN | A_ARR_BEGIN | A_STRING | A_NUMBER | A_BOOL | A_NULL;
  localparam logic [MASK_W-1:0] A_CONT_OBJ = A_NEXT | A_KEY | A_OBJ_END;
  localparam logic [MASK_W-1:0] A_CONT_ARR = A_NEXT | A_VALUES_ONLY | A_VALUE | A_ARR_END;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  typedef enum logic [3:0] {
    M_OBJ_BEGIN = 4'd0,
    M_OBJ_END   = 4'd1,
    M_ARR_BEGIN = 4'd2,
    M_ARR_END   = 4'd3,
    M_KEY       = 4'd4,
    M_STRING    = 4'd5,
    M_INT       = 4'd6,
    M_TRUE      = 4'd7,
    M_FALSE     = 4'd8,
    M_NULL      = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_ALLOWED = 2'd1,
    STAT_DEPTH       = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_CONV,
    SQ_EMIT,
    SQ_FLUSH
  } seq_e;

  typedef enum logic [3:0] {
    PH_COMMA,
    PH_CR,
    PH_SPACE,
    PH_OPEN,
    PH_TEXT,
    PH_ESC,
    PH_CLOSE,
    PH_COLON,
    PH_CSPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_LIT,
    PH_END
  } phase_e;

  typedef struct packed {
    status_e         status;
    logic            comma;
    logic            cr;
    logic [SP_W-1:0] nspace;
    logic            open_en;
    logic [7:0]      open_byte;
    logic            text_en;
    logic            text_esc;
    logic [7:0]      text_char;
    logic            close;
    logic            colon;
    logic            cspace;
    logic            is_int;
    logic            lit_en;
    logic [1:0]      lit_sel;
  } plan_t;

  function automatic logic has_bits(input logic [MASK_W-1:0] m, input logic [MASK_W-1:0] b);
    return (m & b) == b;
  endfunction

  function automatic logic [7:0] esc_char(input logic [7:0] b);
    logic [7:0] e;
    case (b)
      8'h22:   e = 8'h22;
      8'h5C:   e = 8'h5C;
      8'h08:   e = 8'h62;
      8'h0C:   e = 8'h66;
      8'h0A:   e = 8'h6E;
      8'h0D:   e = 8'h72;
      8'h09:   e = 8'h74;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [39:0] s;
    case (sel)
      LIT_TRUE:  s = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
      LIT_FALSE: s = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
      LIT_NULL:  s = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
      default:   s = '0;
    endcase
    return s[idx*8 +: 8];
  endfunction

endpackage

>>> hw/rtl/json_structural_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_structural_writer_top
// Streaming JSON writer with nesting and legality checks.
// ----------------------------------------------------------------------------
// One writing request enters on the s_axis channel (mode in tuser, end of key
// or string text in tlast). The block answers on m_axis with one result per
// JSON byte, tlast on the final one; a refused or byte-less request gives a
// single result with the byte flag low and the status code in tuser.
// Indentation width is written on the cfg channel while the block is idle.
// A request is taken only when the sequencer is idle. It is then loaded and
// converted (an integer goes through the shift and adjust unit), and the
// byte phases follow in order, the space phase once per indentation space,
// the digit phase once for each of the 20 digit slots of an integer and the
// literal phase once per literal character; a flush step then releases the
// final result. Each produced byte waits in a holding register so the final
// one can be marked.
// Emission halts while a result waits on a low m_axis_tready; nothing is lost.
// Reset clears the mask stack top to allow only an object or array, the
// level, the open-text flags and indentation to zero.
// ----------------------------------------------------------------------------
module json_structural_writer_top import jsw_pkg::*; #(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // text_byte, byte_present, first_of_text, int_value
  input  logic [3:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic [2:0]  m_axis_tuser,   // out_valid, status
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  seq_e             sq_q, sq_d;
  phase_e           ph_q, ph_d;
  plan_t            plan, plan_q;
  logic [2:0]       indent_q;
  logic [SP_W-1:0]  cnt_q;
  logic [4:0]       dig_q;
  logic [2:0]       lit_q;
  logic             started_q, neg_q;
  logic             hold_v_q, hold_v_d;
  logic [7:0]       hold_b_q, hold_b_d;
  logic             mv_q, mv_d, ov_q, ov_d, ol_q, ol_d;
  logic [7:0]       ob_q, ob_d;
  logic [1:0]       os_q, os_d;
  logic             s_fire, out_free, step, gen_v, adv, dshift;
  logic [7:0]       gen_b;
  logic [INT_W-1:0] ival, mag;
  logic             bcd_done;
  logic [3:0]       digit;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;
  assign step     = (sq_q == SQ_EMIT) && out_free;
  assign ival     = s_axis_tdata[73:10];
  assign mag      = ival[INT_W-1] ? (~ival + INT_W'(1)) : ival;

  jsw_check #(.MAX_DEPTH(MAX_DEPTH)) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (s_fire),
    .mode_i          (s_axis_tuser),
    .text_byte_i     (s_axis_tdata[7:0]),
    .byte_present_i  (s_axis_tdata[8]),
    .first_of_text_i (s_axis_tdata[9]),
    .last_of_text_i  (s_axis_tlast),
    .indent_i        (indent_q),
    .plan_o          (plan)
  );

  jsw_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_fire && plan.is_int),
    .bin_i   (mag),
    .shift_i (dshift),
    .done_o  (bcd_done),
    .digit_o (digit)
  );

  always_comb begin
    sq_d = sq_q;
    ph_d = ph_q;
    case (sq_q)
      SQ_IDLE: begin
        if (s_fire) begin
          sq_d = SQ_CONV;
          ph_d = PH_COMMA;
        end
      end
      SQ_CONV: begin
        if (bcd_done) sq_d = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (step) begin
          if (ph_q == PH_END) begin
            sq_d = SQ_FLUSH;
          end else if (adv) begin
            ph_d = phase_e'(ph_q + 4'd1);
          end
        end
      end
      SQ_FLUSH: begin
        if (out_free) sq_d = SQ_IDLE;
      end
      default: sq_d = SQ_IDLE;
    endcase
  end

  always_comb begin
    gen_v  = 1'b0;
    gen_b  = 8'h00;
    adv    = 1'b1;
    dshift = 1'b0;
    case (ph_q)
      PH_COMMA: begin gen_v = plan_q.comma;  gen_b = CH_COMMA; end
      PH_CR:    begin gen_v = plan_q.cr;     gen_b = CH_CR;    end
      PH_SPACE: begin
        gen_v = (cnt_q != '0);
        gen_b = CH_SPACE;
        adv   = (cnt_q == '0);
      end
      PH_OPEN:  begin gen_v = plan_q.open_en; gen_b = plan_q.open_byte; end
      PH_TEXT: begin
        gen_v = plan_q.text_en;
        gen_b = plan_q.text_esc ? CH_BSLASH : plan_q.text_char;
      end
      PH_ESC:    begin gen_v = plan_q.text_en && plan_q.text_esc; gen_b = plan_q.text_char; end
      PH_CLOSE:  begin gen_v = plan_q.close;  gen_b = CH_QUOTE; end
      PH_COLON:  begin gen_v = plan_q.colon;  gen_b = CH_COLON; end
      PH_CSPACE: begin gen_v = plan_q.cspace; gen_b = CH_SPACE; end
      PH_SIGN:   begin gen_v = plan_q.is_int && neg_q; gen_b = CH_MINUS; end
      PH_DIGIT: begin
        if (plan_q.is_int) begin
          gen_v  = started_q || (digit != 4'h0) || (dig_q == 5'(BCD_DIGITS - 1));
          gen_b  = {4'h3, digit};
          adv    = (dig_q == 5'(BCD_DIGITS - 1));
          dshift = step;
        end
      end
      PH_LIT: begin
        if (plan_q.lit_en) begin
          gen_v = 1'b1;
          gen_b = lit_char(plan_q.lit_sel, lit_q);
          adv   = (lit_q == lit_len(plan_q.lit_sel) - 3'd1);
        end
      end
      default: adv = 1'b1;
    endcase
  end

  always_comb begin
    mv_d     = mv_q && !m_axis_tready;
    ob_d     = ob_q;
    ov_d     = ov_q;
    os_d     = os_q;
    ol_d     = ol_q;
    hold_v_d = hold_v_q;
    hold_b_d = hold_b_q;
    if (step && gen_v) begin
      hold_v_d = 1'b1;
      hold_b_d = gen_b;
      if (hold_v_q) begin
        mv_d = 1'b1;
        ob_d = hold_b_q;
        ov_d = 1'b1;
        os_d = STAT_OK;
        ol_d = 1'b0;
      end
    end else if (sq_q == SQ_FLUSH && out_free) begin
      mv_d     = 1'b1;
      hold_v_d = 1'b0;
      ol_d     = 1'b1;
      if (hold_v_q) begin
        ob_d = hold_b_q;
        ov_d = 1'b1;
        os_d = STAT_OK;
      end else begin
        ob_d = 8'h00;
        ov_d = 1'b0;
        os_d = plan_q.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q      <= SQ_IDLE;
      ph_q      <= PH_COMMA;
      indent_q  <= '0;
      hold_v_q  <= 1'b0;
      mv_q      <= 1'b0;
      cnt_q     <= '0;
      dig_q     <= '0;
      lit_q     <= '0;
      started_q <= 1'b0;
    end else begin
      sq_q     <= sq_d;
      ph_q     <= ph_d;
      hold_v_q <= hold_v_d;
      mv_q     <= mv_d;
      if (cfg_valid_i && cfg_ready_o) indent_q <= cfg_data_i;
      if (s_fire) begin
        cnt_q     <= plan.nspace;
        dig_q     <= '0;
        lit_q     <= '0;
        started_q <= 1'b0;
      end else if (step) begin
        if (ph_q == PH_SPACE && cnt_q != '0) cnt_q <= cnt_q - SP_W'(1);
        if (dshift) begin
          dig_q     <= dig_q + 5'd1;
          started_q <= started_q || (digit != 4'h0);
        end
        if (ph_q == PH_LIT && plan_q.lit_en) lit_q <= lit_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      plan_q <= plan;
      neg_q  <= ival[INT_W-1];
    end
    hold_b_q <= hold_b_d;
    ob_q     <= ob_d;
    ov_q     <= ov_d;
    os_q     <= os_d;
    ol_q     <= ol_d;
  end

  assign s_axis_tready = (sq_q == SQ_IDLE);
  assign cfg_ready_o   = (sq_q == SQ_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = ob_q;
  assign m_axis_tuser  = {os_q, ov_q};
  assign m_axis_tlast  = ol_q;

  // no request is taken while a byte of the previous one is still held back
  a_no_hold_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> !hold_v_q)
    else $error("request accepted with a held byte");

  // a result without a byte is always the final one of its request
  a_status_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("byte-less result not final");

  // conversion finishes into byte emission
  a_conv_to_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_q == SQ_CONV && bcd_done) |=> (sq_q == SQ_EMIT))
    else $error("sequencer left conversion wrongly");

endmodule

>>> hw/rtl/jsw_bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsw_bcd
// Iterative binary to decimal converter, one shift-and-adjust step a cycle,
// then hands out digits from the most significant end.
// ----------------------------------------------------------------------------
module jsw_bcd import jsw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [INT_W-1:0] bin_i,
  input  logic             shift_i,
  output logic             done_o,
  output logic [3:0]       digit_o
);

  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [INT_W-1:0]     bin_q, bin_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic [BCD_W-1:0]     adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (start_i) begin
      cnt_d = BIT_CNT_W'(INT_W);
      bin_d = bin_i;
      bcd_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - BIT_CNT_W'(1);
      {bcd_d, bin_d} = {adj[BCD_W-2:0], bin_q, 1'b0};
    end else if (shift_i) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o  = (cnt_q == '0);
  assign digit_o = bcd_q[BCD_W-1 -: 4];

endmodule

>>> hw/rtl/jsw_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsw_check
// Nesting state and legality check: holds the accept mask stack, decides
// whether a request is allowed and builds the byte plan for the sequencer.
// ----------------------------------------------------------------------------
module jsw_check import jsw_pkg::*; #(
  parameter int MAX_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [3:0] mode_i,
  input  logic [7:0] text_byte_i,
  input  logic       byte_present_i,
  input  logic       first_of_text_i,
  input  logic       last_of_text_i,
  input  logic [2:0] indent_i,
  output plan_t      plan_o
);

  localparam int LVL_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [MASK_W-1:0] stack_mem [MAX_DEPTH];
  logic [MASK_W-1:0] below_q;
  logic [MASK_W-1:0] top_q, top_d, saved;
  logic [LVL_W-1:0]  level_q, level_d, lb_lvl;
  logic              open_q, open_d, key_q, key_d;
  logic              push, use_text, key_now, lb_en;
  logic [2:0]        ind;
  logic [5:0]        prod;
  logic [7:0]        esc;
  plan_t             plan;

  assign ind   = (indent_i > 3'd4) ? 3'd4 : indent_i;
  assign saved = (top_q[9] ? top_q : ((top_q & ~A_VALUE) | A_KEY)) | A_NEXT;
  assign esc   = esc_char(text_byte_i);
  assign prod  = LVL_MAX_W'(lb_lvl) * ind;

  always_comb begin
    plan     = '0;
    plan.status = STAT_OK;
    top_d    = top_q;
    level_d  = level_q;
    open_d   = open_q;
    key_d    = key_q;
    push     = 1'b0;
    use_text = 1'b0;
    key_now  = key_q;
    lb_en    = 1'b0;
    lb_lvl   = level_q;
    if (open_q) begin
      if (mode_i != (key_q ? M_KEY : M_STRING)) begin
        plan.status = STAT_NOT_ALLOWED;
      end else begin
        use_text = 1'b1;
      end
    end else begin
      case (mode_e'(mode_i))
        M_OBJ_BEGIN, M_ARR_BEGIN: begin
          if (level_q >= LVL_W'(MAX_DEPTH - 1)) begin
            plan.status = STAT_DEPTH;
          end else if (!has_bits(top_q, (mode_i == M_OBJ_BEGIN) ? A_OBJ_BEGIN
                                                                 : A_ARR_BEGIN)) begin
            plan.status = STAT_NOT_ALLOWED;
          end else begin
            plan.comma = top_q[9] && top_q[10];
            lb_en      = top_q[9];
            push       = 1'b1;
            level_d    = level_q + LVL_W'(1);
            top_d      = (mode_i == M_OBJ_BEGIN) ? (A_OBJ_END | A_KEY)
                                                 : (A_ARR_END | A_VALUE | A_VALUES_ONLY);
            plan.open_en   = 1'b1;
            plan.open_byte = (mode_i == M_OBJ_BEGIN) ? CH_LBRACE : CH_LBRACK;
          end
        end
        M_OBJ_END, M_ARR_END: begin
          if (level_q == '0 || !has_bits(top_q, (mode_i == M_OBJ_END) ? A_OBJ_END
                                                                     : A_ARR_END)) begin
            plan.status = STAT_NOT_ALLOWED;
          end else begin
            level_d = level_q - LVL_W'(1);
            top_d   = below_q[9] ? A_CONT_ARR : A_CONT_OBJ;
            lb_en   = 1'b1;
            lb_lvl  = level_q - LVL_W'(1);
            plan.open_en   = 1'b1;
            plan.open_byte = (mode_i == M_OBJ_END) ? CH_RBRACE : CH_RBRACK;
          end
        end
        M_KEY: begin
          if (!first_of_text_i || !has_bits(top_q, A_KEY)) begin
            plan.status = STAT_NOT_ALLOWED;
          end else begin
            plan.comma     = top_q[10];
            lb_en          = 1'b1;
            top_d          = A_VALUE;
            plan.open_en   = 1'b1;
            plan.open_byte = CH_QUOTE;
            open_d         = 1'b1;
            key_d          = 1'b1;
            use_text       = 1'b1;
            key_now        = 1'b1;
          end
        end
        M_STRING, M_INT, M_TRUE, M_FALSE, M_NULL: begin
          if ((mode_i == M_STRING && !first_of_text_i) || !has_bits(top_q, A_VALUE)) begin
            plan.status = STAT_NOT_ALLOWED;
          end else begin
            plan.comma = top_q[9] && top_q[10];
            lb_en      = top_q[9];
            top_d      = top_q[9] ? A_CONT_ARR : A_CONT_OBJ;
            case (mode_e'(mode_i))
              M_STRING: begin
                plan.open_en   = 1'b1;
                plan.open_byte = CH_QUOTE;
                open_d         = 1'b1;
                key_d          = 1'b0;
                use_text       = 1'b1;
                key_now        = 1'b0;
              end
              M_INT:   plan.is_int = 1'b1;
              M_TRUE:  begin plan.lit_en = 1'b1; plan.lit_sel = LIT_TRUE;  end
              M_FALSE: begin plan.lit_en = 1'b1; plan.lit_sel = LIT_FALSE; end
              default: begin plan.lit_en = 1'b1; plan.lit_sel = LIT_NULL;  end
            endcase
          end
        end
        default: plan.status = STAT_NOT_ALLOWED;
      endcase
    end
    if (lb_en && ind != 3'd0) begin
      plan.cr     = 1'b1;
      plan.nspace = prod[SP_W-1:0];
    end
    if (use_text) begin
      plan.text_en   = byte_present_i;
      plan.text_esc  = (esc != 8'h00);
      plan.text_char = (esc != 8'h00) ? esc : text_byte_i;
      if (last_of_text_i) begin
        plan.close  = 1'b1;
        plan.colon  = key_now;
        plan.cspace = key_now && (ind != 3'd0);
        open_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= A_OBJ_BEGIN | A_ARR_BEGIN;
      level_q <= '0;
      open_q  <= 1'b0;
      key_q   <= 1'b0;
    end else if (accept_i) begin
      top_q   <= top_d;
      level_q <= level_d;
      open_q  <= open_d;
      key_q   <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && push) begin
      stack_mem[level_q] <= saved;
    end
    below_q <= stack_mem[level_q - LVL_W'(1)];
  end

  assign plan_o = plan;

endmodule
